### rtl/pce_pkg.sv
// shared types and constants for the polynomial coefficient engine
package pce_pkg;

   localparam int TermsDefault = 32;

   typedef enum logic [3:0] {
      OP_SET   = 4'd0,
      OP_ACC   = 4'd1,
      OP_CLEAR = 4'd2,
      OP_DUMP  = 4'd3,
      OP_EVAL  = 4'd4,
      OP_DERIV = 4'd5,
      OP_SUM   = 4'd6,
      OP_DIFF  = 4'd7,
      OP_PROD  = 4'd8
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_DEGREE = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_WRITE_REQ,
      CMD_CLEAR_ROW,
      CMD_EVAL_MUL,
      CMD_EVAL_STEP,
      CMD_DERIV_ROW,
      CMD_ADDSUB_ROW,
      CMD_DEGREE_ROW,
      CMD_PROD_INIT,
      CMD_PROD_MAC,
      CMD_PROD_SAT,
      CMD_EMIT_ROW
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] idx_i;
      logic [6:0] idx_j;
      logic       use_result;
      logic       clear_flag;
   } ctrl_type;

   typedef struct packed {
      logic degree_bad;
      logic flag;
   } stat_type;

endpackage

### rtl/polynomial_coefficient_engine.sv
// top level of the polynomial coefficient engine
//
// requests enter on req_*: tuser carries the opcode, tdata the exponent,
// coefficient and evaluation point. results leave on rsp_* with tlast on the
// final result of a request. csr_* writes target_poly; the user must write it
// only while the block is idle, the block itself does not enforce this.
// one request is worked at a time; req_tready is high only between requests.
// evaluate uses Horner's rule, each multiply done in halves. product: a
// TERMS*TERMS degree scan, then up to TERMS*(TERMS+1)/2 multiply-accumulates
// on one shared MAC, then a saturate and an emit pass.
// reset clears all three stores at once through per-entry valid bits and
// returns target_poly to A. a stalled rsp_tready holds the output register
// and pauses result emission; nothing is dropped.
module polynomial_coefficient_engine #(
   parameter int TERMS = pce_pkg::TermsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,   // opcode
   input  logic [71:0] req_tdata,   // exponent, coef_value, x_value (+2 unused bits)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status, term_index, result_value
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import pce_pkg::*;

   ctrl_type           ctrl;
   stat_type           stat;
   logic               target_ff;
   logic [3:0]         op_ff;
   logic [5:0]         exp_ff;
   logic signed [31:0] coef_ff, x_ff;
   logic signed [47:0] acc_out, rsp_value;
   logic signed [31:0] row_value;
   logic               row_sat;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_index;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) target_ff <= 1'b0;
      else if (csr_valid) target_ff <= csr_data;
      if (req_tvalid && req_tready) begin
         coef_ff <= req_tdata[37:6];
         x_ff    <= req_tdata[69:38];
      end
   end

   pce_controller #(.TERMS(TERMS)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(req_tuser), .req_exponent(req_tdata[5:0]),
      .op_ff, .exp_ff, .ctrl, .stat, .acc_out, .row_value, .row_sat,
      .rsp_tvalid, .rsp_tready, .rsp_status, .rsp_index, .rsp_value, .rsp_tlast
   );

   pce_datapath #(.TERMS(TERMS)) u_dp (
      .clock, .reset, .ctrl, .target(target_ff), .op(op_ff), .exponent(exp_ff),
      .coef_value(coef_ff), .x_value(x_ff), .stat, .acc_out, .row_value, .row_sat
   );

   assign rsp_tdata = {rsp_value, rsp_index, rsp_status};

endmodule

### rtl/pce_datapath.sv
// coefficient stores, shared multiply-accumulate and result formatting
module pce_datapath #(
   parameter int TERMS = pce_pkg::TermsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  pce_pkg::ctrl_type  ctrl,
   input  logic               target,
   input  logic [3:0]         op,
   input  logic [5:0]         exponent,
   input  logic signed [31:0] coef_value,
   input  logic signed [31:0] x_value,
   output pce_pkg::stat_type  stat,
   output logic signed [47:0] acc_out,
   output logic signed [31:0] row_value,
   output logic               row_sat
);
   import pce_pkg::*;

   localparam int IW = (TERMS > 1) ? $clog2(TERMS) : 1;
   localparam logic signed [47:0] Max48 = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] Min48 = {1'b1, {47{1'b0}}};

   logic signed [31:0] a_mem [TERMS];
   logic signed [31:0] b_mem [TERMS];
   logic signed [31:0] r_mem [TERMS];
   logic [TERMS-1:0]   a_vld_ff, b_vld_ff, r_vld_ff;
   logic [TERMS-1:0]   r_sat_ff;
   logic signed [63:0] sums [TERMS];

   logic signed [47:0] acc_ff, acc_in;
   logic               flag_ff, flag_in;
   logic               bad_ff, bad_in;
   logic signed [48:0] plo_ff, plo_in;
   logic [IW-1:0]      ii, jj, kk;
   logic signed [31:0] a_i, b_i, b_j, t_i, tgt_e;
   logic signed [32:0] addsub;
   logic signed [63:0] prod;
   logic signed [16:0] acc_lo;
   logic signed [31:0] acc_hi;
   logic signed [63:0] phi;
   logic signed [79:0] hmul;
   logic signed [63:0] hsh;
   logic signed [48:0] hsum;
   logic signed [47:0] hmid;
   logic               hsat;
   logic signed [32:0] accsum;
   logic signed [31:0] d_src, d_val, wr_val;
   logic               d_sat, wr_sat;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                                 output logic f);
      f = 1'b0;
      if (v > 64'sh7FFFFFFF) begin
         f = 1'b1;
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sh80000000) begin
         f = 1'b1;
         return -32'sh80000000;
      end
      return v[31:0];
   endfunction

   assign ii = ctrl.idx_i[IW-1:0];
   assign jj = ctrl.idx_j[IW-1:0];
   assign kk = IW'(ctrl.idx_i + ctrl.idx_j);

   always_comb begin
      a_i   = a_vld_ff[ii] ? a_mem[ii] : '0;
      b_i   = b_vld_ff[ii] ? b_mem[ii] : '0;
      b_j   = b_vld_ff[jj] ? b_mem[jj] : '0;
      t_i   = target ? b_i : a_i;
      tgt_e = target ? (b_vld_ff[exponent[IW-1:0]] ? b_mem[exponent[IW-1:0]] : '0)
                     : (a_vld_ff[exponent[IW-1:0]] ? a_mem[exponent[IW-1:0]] : '0);
      addsub = (op == OP_SUM) ? (33'(a_i) + 33'(b_i)) : (33'(a_i) - 33'(b_i));
      accsum = 33'(tgt_e) + 33'(coef_value);
      prod   = 64'(a_i) * 64'(b_j);
      // horner multiply split in halves: the low 16 bits are registered first, then the high part is added
      acc_lo = {1'b0, acc_ff[15:0]};
      acc_hi = acc_ff[47:16];
      plo_in = acc_lo * x_value;
      phi    = acc_hi * x_value;
      hmul   = {phi, 16'h0000} + 80'(plo_ff);
      hsh    = hmul[79:16];
      hsat   = 1'b0;
      if (hsh > 64'(Max48)) begin
         hmid = Max48;
         hsat = 1'b1;
      end else if (hsh < 64'(Min48)) begin
         hmid = Min48;
         hsat = 1'b1;
      end else begin
         hmid = hsh[47:0];
      end
      hsum = 49'(hmid) + 49'(t_i);
      d_src = target ? (b_vld_ff[ii + IW'(1)] ? b_mem[ii + IW'(1)] : '0)
                     : (a_vld_ff[ii + IW'(1)] ? a_mem[ii + IW'(1)] : '0);
      d_val = sat32(64'(d_src) * 64'(ctrl.idx_i + 7'd1), d_sat);
      if (op == OP_SET) begin
         wr_val = coef_value;
         wr_sat = 1'b0;
      end else begin
         wr_val = sat32(64'(accsum), wr_sat);
      end
   end

   always_comb begin
      acc_in  = ctrl.clear_flag ? '0 : acc_ff;
      flag_in = ctrl.clear_flag ? 1'b0 : flag_ff;
      bad_in  = ctrl.clear_flag ? 1'b0 : bad_ff;
      unique case (ctrl.cmd)
         CMD_WRITE_REQ: begin
            acc_in  = 48'(wr_val);
            flag_in = wr_sat;
         end
         CMD_EVAL_STEP: begin
            flag_in = flag_in | hsat;
            if (hsum > 49'(Max48)) begin
               acc_in  = Max48;
               flag_in = 1'b1;
            end else if (hsum < 49'(Min48)) begin
               acc_in  = Min48;
               flag_in = 1'b1;
            end else begin
               acc_in = hsum[47:0];
            end
         end
         CMD_DEGREE_ROW: begin
            if (a_i != 0 && b_j != 0 && (ctrl.idx_i + ctrl.idx_j) >= 7'(TERMS))
               bad_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      logic f;
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
         r_vld_ff <= '0;
         acc_ff   <= '0;
         flag_ff  <= 1'b0;
         bad_ff   <= 1'b0;
         plo_ff   <= '0;
      end else begin
         acc_ff  <= acc_in;
         flag_ff <= flag_in;
         bad_ff  <= bad_in;
         plo_ff  <= plo_in;
         unique case (ctrl.cmd)
            CMD_WRITE_REQ: begin
               if (target) begin
                  b_mem[exponent[IW-1:0]]    <= wr_val;
                  b_vld_ff[exponent[IW-1:0]] <= 1'b1;
               end else begin
                  a_mem[exponent[IW-1:0]]    <= wr_val;
                  a_vld_ff[exponent[IW-1:0]] <= 1'b1;
               end
            end
            CMD_CLEAR_ROW: begin
               if (target) b_vld_ff[ii] <= 1'b0;
               else a_vld_ff[ii] <= 1'b0;
            end
            CMD_DERIV_ROW: begin
               if (ctrl.idx_i == 7'(TERMS - 1)) begin
                  r_mem[ii]    <= '0;
                  r_sat_ff[ii] <= 1'b0;
               end else begin
                  r_mem[ii]    <= d_val;
                  r_sat_ff[ii] <= d_sat;
               end
               r_vld_ff[ii] <= 1'b1;
            end
            CMD_ADDSUB_ROW: begin
               r_mem[ii]    <= sat32(64'(addsub), f);
               r_sat_ff[ii] <= f;
               r_vld_ff[ii] <= 1'b1;
            end
            CMD_PROD_INIT: sums[ii] <= '0;
            CMD_PROD_MAC: begin
               if (32'(ctrl.idx_i) + 32'(ctrl.idx_j) < TERMS)
                  sums[kk] <= sums[kk] + (prod >>> 16);
            end
            CMD_PROD_SAT: begin
               r_mem[ii]    <= sat32(sums[ii], f);
               r_sat_ff[ii] <= f;
               r_vld_ff[ii] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      row_value = '0;
      row_sat   = 1'b0;
      if (ctrl.use_result) begin
         if (r_vld_ff[ii]) begin
            row_value = r_mem[ii];
            row_sat   = r_sat_ff[ii];
         end
      end else begin
         row_value = t_i;
      end
   end

   assign acc_out         = acc_ff;
   assign stat.flag       = flag_ff;
   assign stat.degree_bad = bad_ff;

endmodule

### rtl/pce_controller.sv
// sequencer that walks each request through the datapath and the output register
module pce_controller #(
   parameter int TERMS = pce_pkg::TermsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [3:0]         req_op,
   input  logic [5:0]         req_exponent,
   output logic [3:0]         op_ff,
   output logic [5:0]         exp_ff,
   output pce_pkg::ctrl_type  ctrl,
   input  pce_pkg::stat_type  stat,
   input  logic signed [47:0] acc_out,
   input  logic signed [31:0] row_value,
   input  logic               row_sat,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_index,
   output logic signed [47:0] rsp_value,
   output logic               rsp_tlast
);
   import pce_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_CLEAR  = 9'b000000100,
      S_EVAL   = 9'b000001000,
      S_ROWS   = 9'b000010000,
      S_DEGREE = 9'b000100000,
      S_MAC    = 9'b001000000,
      S_EMIT   = 9'b010000000,
      S_SINGLE = 9'b100000000
   } state_type;

   localparam logic [6:0] Last = 7'(TERMS - 1);

   // kind of single result, held in j while in S_SINGLE
   localparam logic [6:0] ResWrite  = 7'd0;
   localparam logic [6:0] ResRange  = 7'd1;
   localparam logic [6:0] ResEval   = 7'd2;
   localparam logic [6:0] ResClear  = 7'd3;
   localparam logic [6:0] ResDegree = 7'd4;

   state_type  state_ff, state_in;
   logic [6:0] i_ff, i_in, j_ff, j_in;
   logic       emit_res_ff, emit_res_in;
   logic       ov_ff, ov_in;
   logic [1:0] st_ff, st_in;
   logic [5:0] ix_ff, ix_in;
   logic signed [47:0] val_ff, val_in;
   logic       last_ff, last_in;
   logic [3:0] op_in;
   logic [5:0] exp_in;
   logic       free;

   assign free       = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      emit_res_in = emit_res_ff;
      op_in       = op_ff;
      exp_in      = exp_ff;
      ov_in       = ov_ff && !rsp_tready;
      st_in       = st_ff;
      ix_in       = ix_ff;
      val_in      = val_ff;
      last_in     = last_ff;
      ctrl        = '0;
      ctrl.idx_i  = i_ff;
      ctrl.idx_j  = j_ff;
      ctrl.use_result = emit_res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_op;
               exp_in   = req_exponent;
               i_in     = '0;
               j_in     = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.clear_flag = 1'b1;
            unique case (op_ff)
               OP_SET, OP_ACC: begin
                  if (7'(exp_ff) >= 7'(TERMS)) begin
                     state_in = S_SINGLE;
                     j_in     = ResRange;
                  end else begin
                     ctrl.cmd = CMD_WRITE_REQ;
                     state_in = S_SINGLE;
                     j_in     = ResWrite;
                  end
               end
               OP_CLEAR: state_in = S_CLEAR;
               OP_DUMP: begin
                  emit_res_in = 1'b0;
                  state_in    = S_EMIT;
               end
               OP_EVAL: begin
                  i_in     = Last;
                  state_in = S_EVAL;
               end
               OP_DERIV, OP_SUM, OP_DIFF: state_in = S_ROWS;
               OP_PROD: state_in = S_DEGREE;
               default: state_in = S_IDLE;
            endcase
         end
         S_CLEAR: begin
            ctrl.cmd = CMD_CLEAR_ROW;
            if (i_ff == Last) begin
               j_in     = ResClear;
               state_in = S_SINGLE;
            end else begin
               i_in = i_ff + 7'd1;
            end
         end
         S_EVAL: begin
            if (j_ff == 7'd0) begin
               ctrl.cmd = CMD_EVAL_MUL;
               j_in     = 7'd1;
            end else begin
               ctrl.cmd = CMD_EVAL_STEP;
               j_in     = 7'd0;
               if (i_ff == 7'd0) begin
                  j_in     = ResEval;
                  state_in = S_SINGLE;
               end else begin
                  i_in = i_ff - 7'd1;
               end
            end
         end
         S_ROWS: begin
            ctrl.cmd = (op_ff == OP_DERIV) ? CMD_DERIV_ROW : CMD_ADDSUB_ROW;
            if (i_ff == Last) begin
               i_in        = '0;
               emit_res_in = 1'b1;
               state_in    = S_EMIT;
            end else begin
               i_in = i_ff + 7'd1;
            end
         end
         S_DEGREE: begin
            ctrl.cmd = CMD_DEGREE_ROW;
            if (j_ff == Last) begin
               j_in = '0;
               if (i_ff == Last) begin
                  i_in     = '0;
                  j_in     = 7'd0;
                  state_in = S_MAC;
               end else begin
                  i_in = i_ff + 7'd1;
               end
            end else begin
               j_in = j_ff + 7'd1;
            end
         end
         S_MAC: begin
            if (stat.degree_bad) begin
               j_in     = ResDegree;
               state_in = S_SINGLE;
            end else if (j_ff == 7'd0 && i_ff == 7'd0 && !emit_res_ff) begin
               ctrl.cmd    = CMD_PROD_INIT;
               emit_res_in = 1'b1;
            end else if (j_ff == 7'd0 && emit_res_ff && i_ff != Last) begin
               ctrl.cmd = CMD_PROD_INIT;
               ctrl.idx_i = i_ff + 7'd1;
               i_in     = i_ff + 7'd1;
               if (i_ff + 7'd1 == Last) begin
                  i_in        = '0;
                  j_in        = 7'd1;
                  emit_res_in = 1'b0;
               end
            end else if (j_ff == 7'd0 && emit_res_ff) begin
               i_in        = '0;
               j_in        = 7'd1;
               emit_res_in = 1'b0;
            end else if (j_ff >= 7'd1 && j_ff <= 7'(TERMS)) begin
               ctrl.cmd   = CMD_PROD_MAC;
               ctrl.idx_j = j_ff - 7'd1;
               if (i_ff + j_ff - 7'd1 >= Last || j_ff == 7'(TERMS)) begin
                  j_in = 7'd1;
                  if (i_ff == Last) begin
                     i_in = '0;
                     j_in = 7'(TERMS + 1);
                  end else begin
                     i_in = i_ff + 7'd1;
                  end
               end else begin
                  j_in = j_ff + 7'd1;
               end
            end else begin
               ctrl.cmd = CMD_PROD_SAT;
               if (i_ff == Last) begin
                  i_in        = '0;
                  emit_res_in = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  i_in = i_ff + 7'd1;
               end
            end
         end
         S_EMIT: begin
            if (free) begin
               ov_in   = 1'b1;
               st_in   = row_sat ? ST_SAT : ST_OK;
               ix_in   = 6'(i_ff);
               val_in  = 48'(row_value);
               last_in = (i_ff == Last);
               if (i_ff == Last) begin
                  i_in     = '0;
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 7'd1;
               end
            end
         end
         S_SINGLE: begin
            if (free) begin
               ov_in   = 1'b1;
               last_in = 1'b1;
               ix_in   = '0;
               val_in  = '0;
               st_in   = ST_OK;
               unique case (j_ff)
                  ResWrite: begin
                     st_in  = stat.flag ? ST_SAT : ST_OK;
                     ix_in  = exp_ff;
                     val_in = acc_out;
                  end
                  ResRange: st_in = ST_RANGE;
                  ResEval: begin
                     st_in  = stat.flag ? ST_SAT : ST_OK;
                     val_in = acc_out;
                  end
                  ResDegree: st_in = ST_DEGREE;
                  default: ;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ov_ff       <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         emit_res_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ov_ff       <= ov_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         emit_res_ff <= (state_ff == S_EXEC && op_ff == OP_PROD) ? 1'b0 : emit_res_in;
      end
      op_ff   <= op_in;
      exp_ff  <= exp_in;
      st_ff   <= st_in;
      ix_ff   <= ix_in;
      val_ff  <= val_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_status = st_ff;
   assign rsp_index  = ix_ff;
   assign rsp_value  = val_ff;
   assign rsp_tlast  = last_ff;

endmodule
